>>> rtl/core/epm_pkg.sv
// ----------------------------------------------------------------------------
// epm_pkg
// Shared types, constants and index helpers for the entropy pool mixer.
// ----------------------------------------------------------------------------
package epm_pkg;

  localparam int unsigned POOL_WORDS = 16;
  localparam int unsigned IDX_W      = $clog2(POOL_WORDS);
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned FOLD_SHIFT = 13;

  localparam logic [WORD_W-1:0] MIXER_RESET = 64'hD1B5_4A32_D192_ED03;
  localparam logic [WORD_W-1:0] GOLDEN      = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MUL_A       = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MUL_B       = 64'h94D0_49BB_1331_11EB;

  localparam logic [1:0] MODE_MIX   = 2'd0;
  localparam logic [1:0] MODE_RAND  = 2'd1;
  localparam logic [1:0] MODE_URAND = 2'd2;
  localparam logic [1:0] MODE_SEED  = 2'd3;

  typedef enum logic [1:0] {
    KIND_MIX,
    KIND_RAND,
    KIND_URAND,
    KIND_SEED
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADD,
    BK_FOLD,
    BK_MULA,
    BK_MULB,
    BK_URX,
    BK_URD,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] sample;
    logic [WORD_W-1:0] timestamp;
    logic [IDX_W-1:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] w);
    return (w == IDX_W'(POOL_WORDS - 1)) ? '0 : w + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_back(logic [IDX_W-1:0] w, logic [2:0] k);
    int t;
    t = int'(w) - int'(k);
    for (int i = 0; i < 2; i++) begin
      if (t < 0) begin
        t = t + int'(POOL_WORDS);
      end
    end
    return IDX_W'(t);
  endfunction

  function automatic logic [IDX_W-1:0] slot_wrap(logic [SLOT_W-1:0] s);
    int t;
    t = int'(s);
    for (int i = 0; i < 3; i++) begin
      if (t >= int'(POOL_WORDS)) begin
        t = t - int'(POOL_WORDS);
      end
    end
    return IDX_W'(t);
  endfunction

  function automatic logic [WORD_W-1:0] xorshift(logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] r;
    r = s ^ (s << 13);
    r = r ^ (r >> 7);
    r = r ^ (r << 17);
    return r;
  endfunction

endpackage

>>> rtl/core/epm_ram.sv
// ----------------------------------------------------------------------------
// epm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module epm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/epm_mul.sv
// ----------------------------------------------------------------------------
// epm_mul
// Low 64 bits of a 64x64 product in three steps on one 32x32 multiplier.
// ----------------------------------------------------------------------------
module epm_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  epm_pkg::mul_req_t                 req_i,
  output logic [epm_pkg::WORD_W-1:0]        res_o,
  output logic                              done_o
);

  logic [epm_pkg::WORD_W-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [1:0]                 step_q, step_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [31:0]                op_x, op_y;
  logic [63:0]                prod;

  always_comb begin
    case (step_q)
      2'd0: begin
        op_x = a_q[31:0];
        op_y = b_q[31:0];
      end
      2'd1: begin
        op_x = a_q[63:32];
        op_y = b_q[31:0];
      end
      default: begin
        op_x = a_q[31:0];
        op_y = b_q[63:32];
      end
    endcase
    prod = op_x * op_y;
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == 2'd0) begin
        acc_d = prod;
      end else begin
        acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      end
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign res_o  = acc_q;
  assign done_o = done_q;

endmodule

>>> rtl/core/epm_front.sv
// ----------------------------------------------------------------------------
// epm_front
// Input stage: decode the mode, wrap the slot and hold words in a two-entry queue.
// ----------------------------------------------------------------------------
module epm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [epm_pkg::WORD_W-1:0]          sample_i,
  input  logic [epm_pkg::WORD_W-1:0]          timestamp_i,
  input  logic [epm_pkg::SLOT_W-1:0]          slot_i,
  output logic                                cmd_valid_o,
  output epm_pkg::cmd_t                       cmd_o,
  input  logic                                cmd_pop_i
);

  epm_pkg::cmd_t q_mem_q [2];
  epm_pkg::cmd_t cmd_in;
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;

  always_comb begin
    unique case (mode_i)
      epm_pkg::MODE_MIX:   cmd_in.kind = epm_pkg::KIND_MIX;
      epm_pkg::MODE_RAND:  cmd_in.kind = epm_pkg::KIND_RAND;
      epm_pkg::MODE_URAND: cmd_in.kind = epm_pkg::KIND_URAND;
      epm_pkg::MODE_SEED:  cmd_in.kind = epm_pkg::KIND_SEED;
      default:             cmd_in.kind = epm_pkg::KIND_MIX;
    endcase
    cmd_in.sample    = sample_i;
    cmd_in.timestamp = timestamp_i;
    cmd_in.slot      = epm_pkg::slot_wrap(slot_i);
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/core/epm_back.sv
// ----------------------------------------------------------------------------
// epm_back
// Execution sequencer: pool update, state fold, finaliser and byte output.
// ----------------------------------------------------------------------------
module epm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  epm_pkg::cmd_t                cmd_i,
  output logic                         cmd_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   random_byte_o
);

  localparam int unsigned W  = epm_pkg::WORD_W;
  localparam int unsigned IW = epm_pkg::IDX_W;

  epm_pkg::bk_state_e state_q, state_d;

  logic [W-1:0]  mix_q, mix_d, v_q, v_d, ts_q, ts_d, t_q, t_d, acc_q, acc_d;
  logic [IW-1:0] widx_q, widx_d;
  epm_pkg::kind_e kind_q, kind_d;
  logic          second_q, second_d;
  logic [1:0]    ph_q, ph_d;
  logic [7:0]    byte_q, byte_d, out_byte_q, out_byte_d;
  logic          out_valid_q, out_valid_d;
  logic [epm_pkg::POOL_WORDS-1:0] vld_q, vld_d;
  logic          rd_vld_q;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata, rd_eff;

  epm_pkg::mul_req_t mul_req;
  logic [W-1:0]      mul_res;
  logic              mul_done;

  logic [W-1:0]  s1, fin, xs, ur;

  epm_ram #(
    .Width(W),
    .Depth(epm_pkg::POOL_WORDS)
  ) u_pool (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  epm_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .res_o (mul_res),
    .done_o(mul_done)
  );

  assign rd_eff = rd_vld_q ? ram_rdata : '0;
  assign s1     = mix_q ^ (t_q + (mix_q >> 2));
  assign fin    = mul_res ^ (mul_res >> 31) ^ acc_q;
  assign xs     = epm_pkg::xorshift(mix_q);
  assign ur     = mix_q ^ rd_eff;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      epm_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.kind != epm_pkg::KIND_SEED) begin
          state_d = epm_pkg::BK_ADD;
        end
      end
      epm_pkg::BK_ADD:  state_d = epm_pkg::BK_FOLD;
      epm_pkg::BK_FOLD: state_d = epm_pkg::BK_MULA;
      epm_pkg::BK_MULA: begin
        if (mul_done) begin
          state_d = epm_pkg::BK_MULB;
        end
      end
      epm_pkg::BK_MULB: begin
        if (mul_done) begin
          unique case (kind_q)
            epm_pkg::KIND_RAND:  state_d = second_q ? epm_pkg::BK_OUT : epm_pkg::BK_ADD;
            epm_pkg::KIND_URAND: state_d = epm_pkg::BK_URX;
            default:             state_d = epm_pkg::BK_IDLE;
          endcase
        end
      end
      epm_pkg::BK_URX: state_d = epm_pkg::BK_URD;
      epm_pkg::BK_URD: state_d = epm_pkg::BK_OUT;
      epm_pkg::BK_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = epm_pkg::BK_IDLE;
        end
      end
      default: state_d = epm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    mix_d       = mix_q;
    v_d         = v_q;
    ts_d        = ts_q;
    t_d         = t_q;
    acc_d       = acc_q;
    widx_d      = widx_q;
    kind_d      = kind_q;
    second_d    = second_q;
    ph_d        = ph_q;
    byte_d      = byte_q;
    out_byte_d  = out_byte_q;
    out_valid_d = out_valid_q && out_stall_i;
    vld_d       = vld_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = widx_q;
    ram_wdata   = rd_eff ^ v_q;
    ram_raddr   = widx_q;
    mul_req     = '{start: 1'b0, a: s1 ^ (s1 >> 30), b: epm_pkg::MUL_A};

    unique case (state_q)
      epm_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == epm_pkg::KIND_SEED) begin
            ram_we    = 1'b1;
            ram_waddr = cmd_i.slot;
            ram_wdata = cmd_i.sample;
            widx_d    = '0;
          end else begin
            v_d      = cmd_i.sample;
            ts_d     = cmd_i.timestamp;
            kind_d   = cmd_i.kind;
            second_d = 1'b0;
          end
        end
      end
      epm_pkg::BK_ADD: begin
        t_d = v_q + epm_pkg::GOLDEN + (mix_q << 6);
      end
      epm_pkg::BK_FOLD: begin
        ram_we        = 1'b1;
        acc_d         = rd_eff ^ v_q;
        mul_req.start = 1'b1;
        widx_d        = epm_pkg::idx_next(widx_q);
        ram_raddr     = epm_pkg::idx_back(widx_q, 3'd1);
        ph_d          = 2'd1;
      end
      epm_pkg::BK_MULA: begin
        case (ph_q)
          2'd1: acc_d = acc_q ^ (rd_eff << epm_pkg::FOLD_SHIFT);
          2'd2: acc_d = acc_q ^ (rd_eff << (2 * epm_pkg::FOLD_SHIFT));
          2'd3: acc_d = acc_q ^ (rd_eff << (3 * epm_pkg::FOLD_SHIFT));
          default: acc_d = acc_q;
        endcase
        if (ph_q != 2'd0) begin
          ram_raddr = epm_pkg::idx_back(widx_q, {1'b0, ph_q} + 3'd2);
          ph_d      = ph_q + 2'd1;
        end
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: mul_res ^ (mul_res >> 27), b: epm_pkg::MUL_B};
        end
      end
      epm_pkg::BK_MULB: begin
        if (mul_done) begin
          mix_d = fin;
          if (kind_q == epm_pkg::KIND_RAND) begin
            v_d      = ts_q;
            second_d = 1'b1;
            byte_d   = fin[63:56] ^ fin[31:24];
          end
        end
      end
      epm_pkg::BK_URX: begin
        mix_d = xs;
      end
      epm_pkg::BK_URD: begin
        mix_d  = ur;
        widx_d = epm_pkg::idx_next(widx_q);
        byte_d = ur[63:56] ^ ur[7:0];
      end
      epm_pkg::BK_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte_q;
        end
      end
      default: ;
    endcase

    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= epm_pkg::BK_IDLE;
      mix_q       <= epm_pkg::MIXER_RESET;
      widx_q      <= '0;
      ph_q        <= 2'd0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      mix_q       <= mix_d;
      widx_q      <= widx_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
      rd_vld_q    <= vld_q[ram_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    ts_q       <= ts_d;
    t_q        <= t_d;
    acc_q      <= acc_d;
    kind_q     <= kind_d;
    second_q   <= second_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o   = out_valid_q;
  assign random_byte_o = out_byte_q;

endmodule

>>> rtl/core/entropy_pool_mixer.sv
// ----------------------------------------------------------------------------
// entropy_pool_mixer
// Entropy conditioner: pool of sixteen words and a 64-bit finalised state.
// ----------------------------------------------------------------------------
// One mix runs two 64-bit multiplies of three steps each on a single shared
// 32x32 multiplier. A random byte takes two mixes, a urandom byte one mix and
// a pool read, a seed word one pool write; the byte leaves through a register.
// A two-word queue takes new words while the sequencer works.
// Reset clears state, index and pool at once through per-entry valid flags.
module entropy_pool_mixer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  mode_i,
  input  logic [epm_pkg::WORD_W-1:0]  sample_i,
  input  logic [epm_pkg::WORD_W-1:0]  timestamp_i,
  input  logic [epm_pkg::SLOT_W-1:0]  slot_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  random_byte_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  epm_pkg::cmd_t cmd;

  epm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .sample_i   (sample_i),
    .timestamp_i(timestamp_i),
    .slot_i     (slot_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  epm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .random_byte_o(random_byte_o)
  );

endmodule
